@@ src/nkht_pkg.sv @@
`timescale 1ns / 1ps
package nkht_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int NAME_WORDS    = 16;
  localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
  localparam int WRD_W   = (NAME_WORDS > 1) ? $clog2(NAME_WORDS) : 1;
  localparam int ROW_W   = NAME_WORDS * 64;

  typedef enum logic [2:0] {
    FN_LOAD   = 3'd0,
    FN_ADD    = 3'd1,
    FN_LKNAME = 3'd2,
    FN_LKSOCK = 3'd3,
    FN_REMOVE = 3'd4,
    FN_NEXT   = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTUNIQ  = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_RANGE    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_SCAN, S_WALK, S_RDWAIT, S_EMIT, S_RESP
  } state_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [9:0]  socket;
    logic [3:0]  word_index;
    logic [63:0] name_word;
    logic [6:0]  name_length;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  found_socket;
    logic [63:0] out_name_word;
    logic        last;
    logic [6:0]  active_count;
  } rsp_t;

endpackage

@@ src/nkht_row_ram.sv @@
`timescale 1ns / 1ps
module nkht_row_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // registered read port, holds when idle
  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end
endmodule

@@ src/name_keyed_handle_table_top.sv @@
`timescale 1ns / 1ps
// Load, remove and unused codes go from accept to a single result; lookup socket on a valid
// entry reads the row and emits the name words as a run. Add and lookup name: accept, name
// preparation word by word, then a search of the row memory entry by entry until a hit or
// the end of the table, then the result. Next: walk the valid bits from the cursor, then read
// the row and emit the name words, or give a not-found result at the end of the table.
// One item at a time; a finished result waits in the output register.
// Reset (synchronous, rst high) clears stage, valid bits, count and cursor; names stay.
module name_keyed_handle_table_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  nkht_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output nkht_pkg::rsp_t rsp
);
  import nkht_pkg::*;

  state_t state, state_next;

  logic [63:0]        stage [NAME_WORDS];
  logic [ROW_W-1:0]   eff;
  logic               ended;
  logic [WRD_W-1:0]   pk;
  logic [TABLE_ENTRIES-1:0] valid;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   cursor;
  logic [CNT_W-1:0]   walk_idx;
  logic [CNT_W-1:0]   scan_idx;
  logic               cmp_v;
  logic [IDX_W-1:0]   cmp_idx;
  logic [WRD_W-1:0]   wk;
  logic [2:0]         op_func;
  logic [9:0]         op_sock;
  logic [6:0]         op_len;
  logic [1:0]         res_status;
  logic [9:0]         res_sock;
  logic [IDX_W-1:0]   emit_sock;

  logic               rd_en, wr_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [ROW_W-1:0]   rd_row;
  logic               out_free, accept;
  logic               hit, scan_done, sock_oor, walk_end;
  logic [63:0]        pword;
  logic               pend;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;
  assign sock_oor  = 32'(op_sock) >= 32'(TABLE_ENTRIES);
  assign hit       = cmp_v && valid[cmp_idx] && (rd_row == eff);
  assign scan_done = !cmp_v && (32'(scan_idx) >= 32'(TABLE_ENTRIES));
  assign walk_end  = 32'(walk_idx) >= 32'(TABLE_ENTRIES);

  // cut one stage word at the name length or first zero byte
  always_comb begin
    logic e;
    logic [8:0] b;
    logic [7:0] by;
    e     = ended;
    pword = '0;
    for (int j = 0; j < 8; j++) begin
      b  = 9'(32'(pk) * 8 + j);
      by = stage[pk][j*8 +: 8];
      e  = e || (b >= {2'b0, op_len}) || (by == 8'd0);
      if (!e) pword[j*8 +: 8] = by;
    end
    pend = e;
  end

  nkht_row_ram #(.DEPTH(TABLE_ENTRIES), .WIDTH(ROW_W)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (op_sock[IDX_W-1:0]),
    .wr_data (eff),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_row)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // next state and memory controls
  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (req.func)
            FN_ADD, FN_LKNAME: state_next = S_PREP;
            FN_LKSOCK: begin
              if (32'(req.socket) < 32'(TABLE_ENTRIES) && valid[req.socket[IDX_W-1:0]]) begin
                rd_en      = 1'b1;
                rd_addr    = req.socket[IDX_W-1:0];
                state_next = S_RDWAIT;
              end else begin
                state_next = S_RESP;
              end
            end
            FN_NEXT: state_next = S_WALK;
            default: state_next = S_RESP;
          endcase
        end
      end
      S_PREP: begin
        if (32'(pk) == NAME_WORDS - 1) state_next = S_SCAN;
      end
      S_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = scan_idx[IDX_W-1:0];
        if (hit) begin
          state_next = S_RESP;
        end else if (scan_done) begin
          wr_en      = (op_func == FN_ADD) && !sock_oor;
          state_next = S_RESP;
        end
      end
      S_WALK: begin
        if (walk_end) begin
          state_next = S_RESP;
        end else if (valid[walk_idx[IDX_W-1:0]]) begin
          rd_en      = 1'b1;
          rd_addr    = walk_idx[IDX_W-1:0];
          state_next = S_RDWAIT;
        end
      end
      S_RDWAIT: state_next = S_EMIT;
      S_EMIT: begin
        if (out_free && 32'(wk) == NAME_WORDS - 1) state_next = S_IDLE;
      end
      S_RESP: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control state: valid bits, count, cursor, stage
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      count  <= '0;
      cursor <= '0;
      for (int k = 0; k < NAME_WORDS; k++) stage[k] <= '0;
    end else begin
      if (state == S_IDLE && accept) begin
        if (req.func == FN_LOAD) begin
          if (req.word_index == '0) begin
            for (int k = 0; k < NAME_WORDS; k++)
              stage[k] <= (k == 0) ? req.name_word : 64'd0;
          end else if (32'(req.word_index) < NAME_WORDS) begin
            stage[req.word_index[WRD_W-1:0]] <= req.name_word;
          end
        end
        if (req.func == FN_REMOVE && 32'(req.socket) < 32'(TABLE_ENTRIES)
            && valid[req.socket[IDX_W-1:0]]) begin
          valid[req.socket[IDX_W-1:0]] <= 1'b0;
          count <= count - 1'b1;
        end
      end
      if (wr_en && !valid[op_sock[IDX_W-1:0]]) begin
        valid[op_sock[IDX_W-1:0]] <= 1'b1;
        count <= count + 1'b1;
      end
      if (state == S_WALK) begin
        if (walk_end) cursor <= '0;
        else if (valid[walk_idx[IDX_W-1:0]]) cursor <= walk_idx + 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        op_func  <= req.func;
        op_sock  <= req.socket;
        op_len   <= req.name_length;
        pk       <= '0;
        ended    <= 1'b0;
        walk_idx <= cursor;
        wk       <= '0;
        emit_sock <= req.socket[IDX_W-1:0];
        res_sock <= '0;
        unique case (req.func)
          FN_LOAD: res_status <= ST_OK;
          FN_LKSOCK, FN_REMOVE: begin
            if (32'(req.socket) >= 32'(TABLE_ENTRIES)) res_status <= ST_RANGE;
            else if (!valid[req.socket[IDX_W-1:0]])    res_status <= ST_NOTFOUND;
            else begin
              res_status <= ST_OK;
              res_sock   <= req.socket;
            end
          end
          default: res_status <= ST_NOTFOUND;
        endcase
      end
      S_PREP: begin
        eff[32'(pk)*64 +: 64] <= pword;
        ended    <= pend;
        pk       <= pk + 1'b1;
        scan_idx <= '0;
        cmp_v    <= 1'b0;
      end
      S_SCAN: begin
        cmp_v    <= 32'(scan_idx) < 32'(TABLE_ENTRIES);
        cmp_idx  <= scan_idx[IDX_W-1:0];
        scan_idx <= scan_idx + 1'b1;
        if (hit) begin
          res_status <= (op_func == FN_ADD) ? ST_NOTUNIQ : ST_OK;
          res_sock   <= (op_func == FN_ADD) ? 10'd0 : 10'(cmp_idx);
        end else if (op_func == FN_ADD) begin
          res_status <= sock_oor ? ST_RANGE : ST_OK;
          res_sock   <= sock_oor ? 10'd0 : op_sock;
        end else begin
          res_status <= ST_NOTFOUND;
          res_sock   <= '0;
        end
      end
      S_WALK: begin
        emit_sock  <= walk_idx[IDX_W-1:0];
        walk_idx   <= walk_idx + 1'b1;
        res_status <= ST_NOTFOUND;
        res_sock   <= '0;
      end
      S_EMIT: begin
        if (out_free) wk <= wk + 1'b1;
      end
      default: ;
    endcase
  end

  // output register: drop on transfer, load on a new result
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_free) begin
      rsp_valid <= (state == S_EMIT) || (state == S_RESP);
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (state == S_EMIT) begin
        rsp.status        <= ST_OK;
        rsp.found_socket  <= 6'(32'(emit_sock));
        rsp.out_name_word <= rd_row[32'(wk)*64 +: 64];
        rsp.last          <= (32'(wk) == NAME_WORDS - 1);
        rsp.active_count  <= 7'(count);
      end else begin
        rsp.status        <= res_status;
        rsp.found_socket  <= res_sock[5:0];
        rsp.out_name_word <= '0;
        rsp.last          <= 1'b1;
        rsp.active_count  <= 7'(count);
      end
    end
  end

endmodule

@@ src/nkht_checker.sv @@
`timescale 1ns / 1ps
module nkht_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input nkht_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input nkht_pkg::rsp_t rsp
);
  import nkht_pkg::*;

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

  // one item at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("input taken while busy");

  // count stays within the table
  a_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> 32'(rsp.active_count) <= TABLE_ENTRIES)
    else $error("count beyond table size");

  // only successful name runs span several results
  a_run: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.last |-> rsp.status == ST_OK)
    else $error("failed item gave a run");

  // failures carry no socket or name
  a_fail: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.found_socket == '0 && rsp.out_name_word == '0)
    else $error("failure with payload");
endmodule

bind name_keyed_handle_table_top nkht_checker u_nkht_checker (.*);
